FILE: design/arpc_pkg.sv
// shared types and constants of the arp cache responder
`default_nettype none

package arpc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // item kinds
    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_SEND  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DROPPED = 3'd0;
    localparam logic [2:0] ST_LEARNED = 3'd1;
    localparam logic [2:0] ST_REPLY   = 3'd2;
    localparam logic [2:0] ST_HIT     = 3'd3;
    localparam logic [2:0] ST_MISS    = 3'd4;
    localparam logic [2:0] ST_REQUEST = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_IP   = 2'd0;
    localparam logic [1:0] CFG_OWN_MAC  = 2'd1;
    localparam logic [1:0] CFG_IP_VALID = 2'd2;

    localparam logic [15:0] MIN_LEN     = 16'd28;
    localparam logic [15:0] HW_ETHER    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OPC_REQUEST = 16'h0001;
    localparam logic [31:0] BCAST_IP    = 32'hFFFF_FFFF;
    localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] packet_length;
        logic [15:0] hardware_type;
        logic [15:0] protocol_type;
        logic [15:0] arp_opcode;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
        logic [31:0] query_ip;
    } item_t;

    typedef struct packed {
        logic [31:0] own_ip;
        logic        ip_configured;
    } cfg_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      ip;
        logic [47:0]      mac;
    } tbl_wr_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } tbl_ent_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] mac_value;
        logic [31:0] ip_value;
    } res_t;

endpackage

`default_nettype wire

FILE: design/arpc_table.sv
// cache table: ip/mac memory with registered read and per-entry valid flags
`default_nettype none

module arpc_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [arpc_pkg::IDX_W-1:0] rd_addr,
    input  wire arpc_pkg::tbl_wr_t          wr,
    output arpc_pkg::tbl_ent_t              rd_ent
);

    logic [79:0] mem [arpc_pkg::TABLE_ENTRIES];
    logic [arpc_pkg::TABLE_ENTRIES-1:0] valid_reg;
    logic [79:0] rd_data_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.ip, wr.mac};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid flags live in flops so reset empties the table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_ent.valid = rd_valid_reg;
    assign rd_ent.ip    = rd_data_reg[79:48];
    assign rd_ent.mac   = rd_data_reg[47:0];

endmodule

`default_nettype wire

FILE: design/arpc_engine.sv
// per-item sequencer: decode, table scan, learn write-back, result hold
`default_nettype none

module arpc_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire arpc_pkg::item_t             item_in,
    input  wire arpc_pkg::cfg_t              cfg,
    output logic                            idle,
    output logic                            rd_en,
    output logic [arpc_pkg::IDX_W-1:0]       rd_addr,
    input  wire arpc_pkg::tbl_ent_t          rd_ent,
    output arpc_pkg::tbl_wr_t                wr,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output arpc_pkg::res_t                   res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [arpc_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [arpc_pkg::IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic                       issue_reg, issue_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [arpc_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic                       learn_reg, learn_next;
    logic                       reply_reg, reply_next;
    logic [31:0]                key_reg, key_next;
    logic [47:0]                mac_reg, mac_next;
    arpc_pkg::res_t             res_reg, res_next;

    logic hdr_ok;
    logic match;
    logic scan_end;

    assign hdr_ok = (item_in.packet_length >= arpc_pkg::MIN_LEN)
                 && (item_in.hardware_type == arpc_pkg::HW_ETHER)
                 && (item_in.protocol_type == arpc_pkg::PROTO_IPV4);

    // compare stage sees the entry read in the previous cycle
    assign match    = cmp_vld_reg && rd_ent.valid && (rd_ent.ip == key_reg);
    assign scan_end = match || (cmp_vld_reg && (cmp_idx_reg == arpc_pkg::LAST_IDX));

    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        issue_next   = issue_reg;
        cmp_vld_next = 1'b0;
        slot_next    = slot_reg;
        learn_next   = learn_reg;
        reply_next   = reply_reg;
        key_next     = key_reg;
        mac_next     = mac_reg;
        res_next     = res_reg;
        rd_en        = 1'b0;
        rd_addr      = rd_idx_reg;
        wr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next     = item_in.src_ip;
                    mac_next     = item_in.src_mac;
                    learn_next   = 1'b0;
                    reply_next   = (item_in.arp_opcode == arpc_pkg::OPC_REQUEST)
                                && (item_in.dst_ip == cfg.own_ip)
                                && cfg.ip_configured;
                    rd_idx_next  = '0;
                    issue_next   = 1'b1;
                    res_next     = '0;
                    res_next.status = arpc_pkg::ST_DROPPED;
                    state_next   = S_DONE;
                    case (item_in.op)
                        arpc_pkg::OP_RX:
                        begin
                            if (hdr_ok)
                            begin
                                learn_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        arpc_pkg::OP_QUERY:
                        begin
                            if (item_in.query_ip == arpc_pkg::BCAST_IP)
                            begin
                                res_next.status    = arpc_pkg::ST_HIT;
                                res_next.mac_value = arpc_pkg::BCAST_MAC;
                            end
                            else
                            begin
                                key_next   = item_in.query_ip;
                                state_next = S_SCAN;
                            end
                        end
                        arpc_pkg::OP_SEND:
                        begin
                            res_next.status    = arpc_pkg::ST_REQUEST;
                            res_next.mac_value = arpc_pkg::BCAST_MAC;
                            res_next.ip_value  = item_in.query_ip;
                        end
                        default:
                        begin
                            res_next.status = arpc_pkg::ST_DROPPED;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                rd_en        = issue_reg;
                cmp_vld_next = issue_reg;
                cmp_idx_next = rd_idx_reg;
                if (issue_reg)
                begin
                    if (rd_idx_reg == arpc_pkg::LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (scan_end)
                begin
                    rd_en        = 1'b0;
                    cmp_vld_next = 1'b0;
                    issue_next   = 1'b0;
                    state_next   = S_DONE;
                    res_next     = '0;
                    if (learn_reg)
                    begin
                        // update in place on a hit, else replace round robin
                        wr.en   = 1'b1;
                        wr.addr = match ? cmp_idx_reg : slot_reg;
                        wr.ip   = key_reg;
                        wr.mac  = mac_reg;
                        if (!match)
                        begin
                            slot_next = (slot_reg == arpc_pkg::LAST_IDX) ? '0
                                                                         : slot_reg + 1'b1;
                        end
                        if (reply_reg)
                        begin
                            res_next.status    = arpc_pkg::ST_REPLY;
                            res_next.mac_value = mac_reg;
                            res_next.ip_value  = key_reg;
                        end
                        else
                        begin
                            res_next.status = arpc_pkg::ST_LEARNED;
                        end
                    end
                    else if (match)
                    begin
                        res_next.status    = arpc_pkg::ST_HIT;
                        res_next.mac_value = rd_ent.mac;
                    end
                    else
                    begin
                        res_next.status = arpc_pkg::ST_MISS;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_idx_reg  <= '0;
            cmp_idx_reg <= '0;
            issue_reg   <= 1'b0;
            cmp_vld_reg <= 1'b0;
            slot_reg    <= '0;
            learn_reg   <= 1'b0;
            reply_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_idx_reg <= cmp_idx_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
            slot_reg    <= slot_next;
            learn_reg   <= learn_next;
            reply_reg   <= reply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        mac_reg <= mac_next;
        res_reg <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    a_wr_only_at_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_SCAN) && scan_end && learn_reg)
        else $error("table write outside learn completion");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= arpc_pkg::LAST_IDX)
        else $error("replace slot out of range");

    a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && cmp_vld_reg |-> $past(rd_en))
        else $error("compare without preceding read");

    a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == arpc_pkg::ST_DROPPED)
        |-> (res.mac_value == '0) && (res.ip_value == '0))
        else $error("dropped result carries data");

endmodule

`default_nettype wire

FILE: design/arp_cache_responder.sv
// top level: stream ports, configuration registers, output register
`default_nettype none

// arp engine with a 32-entry ip-to-mac cache. an item takes one of three
// kinds (s_axis_tuser): a received arp header, which is learned into the
// cache and may produce a reply; a resolve query; or an outgoing request.
// each item gives exactly one result item. items that touch the cache
// (valid headers and non-broadcast queries) scan the table one entry per
// cycle through its single read port, whose read is registered, and the
// scan ends early at the first matching entry; a learn writes back in the
// cycle that ends the scan. one item is in work at a time; the output
// register lets the next item be accepted while a result still waits on
// m_axis_tready. the table is empty right after reset with no clearing
// pass. configuration writes are always accepted and must only be made
// while the block is idle. own_mac is accepted at index 1 but never shows
// in a result, so it is not held.

module arp_cache_responder (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // packet_length, hardware_type, protocol_type, arp_opcode, src_ip,
    // src_mac, dst_ip, query_ip
    input  wire logic [207:0] s_axis_tdata,
    // op
    input  wire logic [1:0]   s_axis_tuser,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // mac_value, ip_value
    output logic [79:0]       m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser,

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);

    arpc_pkg::item_t    item;
    arpc_pkg::cfg_t     cfg;
    arpc_pkg::tbl_wr_t  tbl_wr;
    arpc_pkg::tbl_ent_t tbl_ent;
    arpc_pkg::res_t     res;

    logic                       eng_idle;
    logic                       start;
    logic                       rd_en;
    logic [arpc_pkg::IDX_W-1:0] rd_addr;
    logic                       res_valid;
    logic                       res_ready;

    logic [31:0] own_ip_reg;
    logic        ip_cfg_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [47:0] out_mac_reg;
    logic [31:0] out_ip_reg;

    // unpack the input item, lowest field first
    assign item.op            = s_axis_tuser;
    assign item.packet_length = s_axis_tdata[15:0];
    assign item.hardware_type = s_axis_tdata[31:16];
    assign item.protocol_type = s_axis_tdata[47:32];
    assign item.arp_opcode    = s_axis_tdata[63:48];
    assign item.src_ip        = s_axis_tdata[95:64];
    assign item.src_mac       = s_axis_tdata[143:96];
    assign item.dst_ip        = s_axis_tdata[175:144];
    assign item.query_ip      = s_axis_tdata[207:176];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
            ip_cfg_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                arpc_pkg::CFG_OWN_IP:   own_ip_reg <= cfg_data[31:0];
                arpc_pkg::CFG_IP_VALID: ip_cfg_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    assign cfg.own_ip        = own_ip_reg;
    assign cfg.ip_configured = ip_cfg_reg;

    // a new item enters whenever the sequencer is free
    assign s_axis_tready = eng_idle;
    assign start         = s_axis_tvalid && eng_idle;

    arpc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_in   (item),
        .cfg       (cfg),
        .idle      (eng_idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_ent    (tbl_ent),
        .wr        (tbl_wr),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    arpc_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (tbl_wr),
        .rd_ent  (tbl_ent)
    );

    // output register decouples the result from the downstream stall
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_status_reg <= res.status;
            out_mac_reg    <= res.mac_value;
            out_ip_reg     <= res.ip_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_ip_reg, out_mac_reg};

endmodule

`default_nettype wire
